/* design/srtf_pkg.sv */
`timescale 1ns / 1ps
package srtf_pkg;

	localparam int SLOT_W  = 8;
	localparam int ID_W    = 16;
	localparam int TIME_W  = 32;
	localparam int LEFT_W  = 16;
	localparam int EV_W    = 2;
	localparam int PEND_W  = 2;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 152;
	localparam int RES_N   = 3;
	localparam int RIDX_W  = 2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [EV_W-1:0] EV_IDLE    = 2'd0;
	localparam logic [EV_W-1:0] EV_RAN     = 2'd1;
	localparam logic [EV_W-1:0] EV_PREEMPT = 2'd2;
	localparam logic [EV_W-1:0] EV_FINISH  = 2'd3;

	localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
	localparam logic [PEND_W-1:0] PEND_MANY = 2'd2;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   ident;
		logic [TIME_W-1:0] arrival;
		logic [LEFT_W-1:0] left;
	} load_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
	} update_t;

	typedef struct packed {
		logic              valid;
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   ident;
		logic [TIME_W-1:0] arrival;
		logic [LEFT_W-1:0] left;
		logic              started;
		logic [TIME_W-1:0] first;
		logic [PEND_W-1:0] pend;
	} token_t;

	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [ID_W-1:0]   tag;
		logic [TIME_W-1:0] seg_begin;
		logic [TIME_W-1:0] seg_length;
		logic [TIME_W-1:0] first_run;
	} result_t;

endpackage

/* design/srtf_cell.sv */
`timescale 1ns / 1ps
module srtf_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srtf_pkg::load_t   ld,
	input  srtf_pkg::update_t upd,
	input  logic [31:0]      now,
	input  srtf_pkg::token_t  tok_in,
	output srtf_pkg::token_t  tok_out
);
	import srtf_pkg::*;

	logic              valid_q;
	logic              started_q;
	logic [ID_W-1:0]   ident_q;
	logic [TIME_W-1:0] arrival_q;
	logic [LEFT_W-1:0] left_q;
	logic [TIME_W-1:0] first_q;
	token_t            tok_q;
	token_t            tok_d;

	logic ld_hit;
	logic upd_hit;
	logic pending;
	logic elig;
	logic better;

	assign ld_hit  = ld.en && (ld.slot == SLOT_W'(IDX));
	assign upd_hit = upd.en && (upd.slot == SLOT_W'(IDX));
	assign pending = valid_q && (left_q != '0);
	assign elig    = pending && (arrival_q <= now);

	assign better = (left_q < tok_in.left) ||
		((left_q == tok_in.left) && ((arrival_q < tok_in.arrival) ||
		((arrival_q == tok_in.arrival) && (ident_q < tok_in.ident))));

	always_comb begin
		tok_d = tok_in;
		if (elig && (!tok_in.found || better)) begin
			tok_d.found   = 1'b1;
			tok_d.slot    = SLOT_W'(IDX);
			tok_d.ident   = ident_q;
			tok_d.arrival = arrival_q;
			tok_d.left    = left_q;
			tok_d.started = started_q;
			tok_d.first   = first_q;
		end
		if (pending && (tok_in.pend != PEND_MANY)) begin
			tok_d.pend = tok_in.pend + PEND_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			started_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_d;
			if (ld_hit) begin
				valid_q   <= 1'b1;
				started_q <= 1'b0;
			end else if (upd_hit) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_hit) begin
			ident_q   <= ld.ident;
			arrival_q <= ld.arrival;
			left_q    <= ld.left;
			first_q   <= '0;
		end else if (upd_hit) begin
			left_q <= left_q - LEFT_W'(1);
			if (!started_q) begin
				first_q <= upd.now;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

/* design/srtf_preemptive_scheduler.sv */
`timescale 1ns / 1ps
// A load transfer produces no result.
// A tick passes a search token through one cell per cycle across all MAX_TASKS cells;
// one to three results follow at one per cycle while m_tready is high.
// The next input transfer is taken once the final result of a tick has been delivered.
// The asynchronous reset clears all slots, the time and the running task; no clearing pass.
module srtf_preemptive_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[3:0], proc_id[19:4], arrival_tick[51:20], burst_len[67:52], zero fill
	input  logic [71:0]  s_tdata,
	// kind
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// proc_tag[15:0], seg_begin[47:16], seg_length[79:48], first_run[111:80],
	// now_tick[143:112], all_done[144], zero fill
	output logic [151:0] m_tdata,
	// event_res
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);
	import srtf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] seg_start_q;
	logic              run_v_q;
	logic [SLOT_W-1:0] run_slot_q;
	logic [ID_W-1:0]   run_ident_q;
	logic              all_done_q;
	logic [RIDX_W-1:0] res_cnt_q;
	logic [RIDX_W-1:0] rd_q;
	result_t           res_q [RES_N];

	token_t  tok [MAX_TASKS+1];
	token_t  pick;
	load_t   ld;
	update_t upd;

	logic in_xfer;
	logic out_xfer;
	logic [SLOT_W-1:0] in_slot;

	result_t           res_d [RES_N];
	logic [RIDX_W-1:0] cnt_d;
	logic              pre;
	logic              same;
	logic              fin;
	logic              done_d;
	logic [TIME_W-1:0] next_time;
	logic [TIME_W-1:0] seg_start_d;
	logic [TIME_W-1:0] first_d;
	result_t           cur_res;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign in_slot  = SLOT_W'(s_tdata[3:0]);

	assign ld.en      = in_xfer && (s_tuser == KIND_LOAD) && (int'(s_tdata[3:0]) < MAX_TASKS);
	assign ld.slot    = in_slot;
	assign ld.ident   = s_tdata[19:4];
	assign ld.arrival = s_tdata[51:20];
	assign ld.left    = s_tdata[67:52];

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = in_xfer && (s_tuser == KIND_TICK);
	end

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		srtf_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.upd     (upd),
			.now     (time_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign pick = tok[MAX_TASKS];

	always_comb begin
		same        = run_v_q && pick.found && (pick.slot == run_slot_q);
		pre         = run_v_q && !same;
		fin         = pick.found && (pick.left == LEFT_W'(1));
		next_time   = time_q + TIME_W'(1);
		seg_start_d = same ? seg_start_q : time_q;
		first_d     = pick.started ? pick.first : time_q;
		done_d      = (pick.pend == PEND_NONE) ||
			((pick.pend == PEND_ONE) && fin);
		for (int k = 0; k < RES_N; k++) begin
			res_d[k] = '0;
		end
		cnt_d = '0;
		if (pre) begin
			res_d[cnt_d].ev         = EV_PREEMPT;
			res_d[cnt_d].tag        = run_ident_q;
			res_d[cnt_d].seg_begin  = seg_start_q;
			res_d[cnt_d].seg_length = time_q - seg_start_q;
			cnt_d = cnt_d + RIDX_W'(1);
		end
		if (fin) begin
			res_d[cnt_d].ev         = EV_FINISH;
			res_d[cnt_d].tag        = pick.ident;
			res_d[cnt_d].seg_begin  = seg_start_d;
			res_d[cnt_d].seg_length = next_time - seg_start_d;
			res_d[cnt_d].first_run  = first_d;
			cnt_d = cnt_d + RIDX_W'(1);
		end
		res_d[cnt_d].ev  = pick.found ? EV_RAN : EV_IDLE;
		res_d[cnt_d].tag = pick.found ? pick.ident : '0;
		cnt_d = cnt_d + RIDX_W'(1);
	end

	assign upd.en   = pick.valid && pick.found;
	assign upd.slot = pick.slot;
	assign upd.now  = time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			seg_start_q <= '0;
			run_v_q     <= 1'b0;
			run_slot_q  <= '0;
			run_ident_q <= '0;
			all_done_q  <= 1'b0;
			res_cnt_q   <= '0;
			rd_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ld.en && run_v_q && (run_slot_q == in_slot)) begin
						run_v_q <= 1'b0;
					end
					if (in_xfer && (s_tuser == KIND_TICK)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pick.valid) begin
						time_q     <= next_time;
						all_done_q <= done_d;
						res_cnt_q  <= cnt_d;
						rd_q       <= '0;
						if (pick.found) begin
							seg_start_q <= seg_start_d;
							run_v_q     <= !fin;
							run_slot_q  <= pick.slot;
							run_ident_q <= pick.ident;
						end else begin
							run_v_q <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (m_tlast) begin
							state_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q + RIDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && pick.valid) begin
			for (int k = 0; k < RES_N; k++) begin
				res_q[k] <= res_d[k];
			end
		end
	end

	assign cur_res  = res_q[rd_q];
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = (rd_q == (res_cnt_q - RIDX_W'(1)));
	assign m_tuser  = cur_res.ev;
	assign m_tdata  = {7'b0, all_done_q, time_q, cur_res.first_run, cur_res.seg_length,
		cur_res.seg_begin, cur_res.tag};

`ifndef ASSERT_OFF
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pick.valid |-> (state_q == ST_SCAN))
		else $error("search token left the chain outside a scan");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("input not ready after the final result of a tick");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_cnt_q != '0) && (rd_q < res_cnt_q)))
		else $error("result read pointer beyond the stored results");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> ((m_tuser == EV_IDLE) || (m_tuser == EV_RAN)))
		else $error("final result of a tick is not a status result");
`endif

endmodule

/* verif/srtf_preemptive_scheduler_tb.sv */
`timescale 1ns / 1ps
module srtf_preemptive_scheduler_tb;
	import srtf_pkg::*;

	localparam int N_SLOTS      = 16;
	localparam int NO_SLOT      = N_SLOTS;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AFTER   = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 105;

	typedef struct packed {
		logic        kind;
		logic [3:0]  slot;
		logic [15:0] proc_id;
		logic [31:0] arrival;
		logic [15:0] burst;
	} sched_item_t;

	typedef struct packed {
		logic [1:0]  ev;
		logic [15:0] tag;
		logic [31:0] seg_start;
		logic [31:0] seg_len;
		logic [31:0] first_at;
		logic [31:0] now;
		logic        done;
		logic        is_last;
	} sched_event_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata  = '0;
	logic         s_tuser  = KIND_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	srtf_preemptive_scheduler #(.MAX_TASKS(N_SLOTS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	sched_item_t  item_q[$];
	sched_event_t pending_events[$];
	logic [31:0]  gen_time = '0;

	logic        tab_valid[N_SLOTS];
	logic [15:0] tab_ident[N_SLOTS];
	logic [31:0] tab_arrival[N_SLOTS];
	logic [15:0] tab_left[N_SLOTS];
	logic        tab_started[N_SLOTS];
	logic [31:0] tab_first[N_SLOTS];
	logic [31:0] sched_time = '0;
	int          run_slot = NO_SLOT;
	logic [31:0] seg_origin = '0;

	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int results_seen = 0;
	int err_count = 0;
	int cycle_count = 0;
	sched_event_t rx_event, rx_want;

	initial begin
		for (int i = 0; i < N_SLOTS; i++) begin
			tab_valid[i]   = 1'b0;
			tab_ident[i]   = '0;
			tab_arrival[i] = '0;
			tab_left[i]    = '0;
			tab_started[i] = 1'b0;
			tab_first[i]   = '0;
		end
	end

	function automatic int draw_gap();
		return ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic bit ahead_of(int a, int b);
		if (tab_left[a] != tab_left[b]) return tab_left[a] < tab_left[b];
		if (tab_arrival[a] != tab_arrival[b]) return tab_arrival[a] < tab_arrival[b];
		return tab_ident[a] < tab_ident[b];
	endfunction

	function automatic string show_event(sched_event_t e);
		return $sformatf("ev %0d tag %h begin %0d len %0d first %0d now %0d done %b last %b",
			e.ev, e.tag, e.seg_start, e.seg_len, e.first_at, e.now, e.done, e.is_last);
	endfunction

	function automatic sched_event_t make_event(logic [1:0] ev, logic [15:0] tag,
			logic [31:0] start, logic [31:0] len, logic [31:0] first, logic is_last);
		sched_event_t e;
		e = '{ev: ev, tag: tag, seg_start: start, seg_len: len, first_at: first,
			now: '0, done: 1'b0, is_last: is_last};
		return e;
	endfunction

	task automatic advance_schedule(input sched_item_t it);
		sched_event_t found[3];
		int n;
		int pick;
		bit done;
		logic [15:0] tag;
		n = 0;
		pick = NO_SLOT;
		done = 1'b1;
		if (it.kind == KIND_LOAD) begin
			tab_valid[it.slot]   = 1'b1;
			tab_ident[it.slot]   = it.proc_id;
			tab_arrival[it.slot] = it.arrival;
			tab_left[it.slot]    = it.burst;
			tab_started[it.slot] = 1'b0;
			tab_first[it.slot]   = '0;
			if (run_slot == int'(it.slot)) run_slot = NO_SLOT;
			return;
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			if (tab_valid[i] && tab_left[i] != 0 && tab_arrival[i] <= sched_time) begin
				if (pick == NO_SLOT || ahead_of(i, pick)) pick = i;
			end
		end
		if (pick != run_slot && run_slot != NO_SLOT) begin
			found[n] = make_event(EV_PREEMPT, tab_ident[run_slot], seg_origin,
				sched_time - seg_origin, '0, 1'b0);
			n++;
			run_slot = NO_SLOT;
		end
		if (pick == NO_SLOT) begin
			sched_time++;
			found[n] = make_event(EV_IDLE, '0, '0, '0, '0, 1'b1);
			n++;
		end else begin
			tag = tab_ident[pick];
			if (run_slot != pick) begin
				run_slot = pick;
				seg_origin = sched_time;
			end
			if (!tab_started[pick]) begin
				tab_started[pick] = 1'b1;
				tab_first[pick] = sched_time;
			end
			tab_left[pick]--;
			sched_time++;
			if (tab_left[pick] == 0) begin
				found[n] = make_event(EV_FINISH, tag, seg_origin, sched_time - seg_origin,
					tab_first[pick], 1'b0);
				n++;
				run_slot = NO_SLOT;
			end
			found[n] = make_event(EV_RAN, tag, '0, '0, '0, 1'b1);
			n++;
		end
		for (int i = 0; i < N_SLOTS; i++)
			if (tab_valid[i] && tab_left[i] != 0) done = 1'b0;
		for (int i = 0; i < n; i++) begin
			found[i].now = sched_time;
			found[i].done = done;
			pending_events.insert(pending_events.size(), found[i]);
		end
	endtask

	task automatic queue_load(input logic [3:0] slot, input logic [15:0] id,
			input logic [31:0] arrival, input logic [15:0] burst);
		sched_item_t it;
		it = '{kind: KIND_LOAD, slot: slot, proc_id: id, arrival: arrival, burst: burst};
		item_q.insert(item_q.size(), it);
	endtask

	task automatic queue_tick();
		sched_item_t it;
		it = '{kind: KIND_TICK, slot: 4'($urandom), proc_id: 16'($urandom),
			arrival: $urandom, burst: 16'($urandom)};
		item_q.insert(item_q.size(), it);
		gen_time++;
	endtask

	initial begin
		logic [31:0] arr;
		logic [15:0] burst;
		logic [15:0] id;
		int r;

		queue_tick();
		queue_load(4'd0, 16'hFFFF, 32'd0, 16'd3);
		queue_load(4'd15, 16'h0000, 32'd0, 16'd3);
		queue_load(4'd7, 16'h0000, 32'd0, 16'd0);
		queue_tick();
		queue_load(4'd3, 16'h0005, gen_time, 16'd1);
		queue_tick();
		queue_tick();
		queue_load(4'd15, 16'h0000, 32'd0, 16'd4);
		queue_tick();
		queue_load(4'd1, 16'h0009, 32'hFFFF_FFFF, 16'hFFFF);
		queue_load(4'd2, 16'h0011, gen_time, 16'd2);
		queue_load(4'd4, 16'h0011, gen_time, 16'd2);
		queue_load(4'd5, 16'hAAAA, 32'h5555_5555, 16'h5555);
		queue_load(4'd6, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA);
		repeat (8) queue_tick();

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 35) begin
				r = $urandom_range(0, 9);
				if (r == 0) arr = $urandom;
				else if (r == 1) arr = '0;
				else arr = gen_time + $urandom_range(0, 4);
				r = $urandom_range(0, 9);
				if (r < 7) burst = 16'($urandom_range(1, 6));
				else if (r == 7) burst = 16'hFFFF;
				else burst = 16'($urandom_range(1, 65535));
				id = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
				queue_load(4'($urandom_range(0, 15)), id, arr, burst);
			end else begin
				queue_tick();
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (item_q.size() != 0 || s_tvalid) @(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= KIND_LOAD;
			send_gap = draw_gap();
		end else begin
			if (s_tvalid && s_tready) begin
				advance_schedule(item_q.pop_front());
				send_gap = draw_gap();
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (item_q.size() != 0) begin
				s_tdata  <= {4'b0, item_q[0].burst, item_q[0].arrival, item_q[0].proc_id,
					item_q[0].slot};
				s_tuser  <= item_q[0].kind;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = draw_gap();
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				rx_event = '{ev: m_tuser, tag: m_tdata[15:0], seg_start: m_tdata[47:16],
					seg_len: m_tdata[79:48], first_at: m_tdata[111:80],
					now: m_tdata[143:112], done: m_tdata[144], is_last: m_tlast};
				if (pending_events.size() == 0) begin
					err_count = err_count + 1;
					if (err_count <= 10)
						$display("Unexpected result transfer: %s", show_event(rx_event));
				end else begin
					rx_want = pending_events.pop_front();
					if (rx_event !== rx_want) begin
						err_count = err_count + 1;
						if (err_count <= 10) begin
							$display("Mismatch expected: %s", show_event(rx_want));
							$display("         actual:   %s", show_event(rx_event));
						end
					end
				end
				recv_gap = draw_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (hold_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
